>>> hw/rtl/swrl_pkg.sv
`default_nettype none

package swrl_pkg;

   // fixed field widths
   localparam int TIME_W       = 32;
   localparam int ID_W         = 16;
   localparam int RATE_W       = 6;
   localparam int WINDOW_W     = 16;
   localparam int CSR_ADDR_W   = 1;
   localparam int CSR_DATA_W   = 16;

   // results one input beat may cause
   localparam int RESULT_CAP   = 16;
   localparam int RESULT_CNT_W = 5;

   // parameter defaults
   localparam int LOG_DEPTH_DEF  = 16;
   localparam int WAIT_DEPTH_DEF = 16;
   localparam int ID_BITS_DEF    = 16;

   // register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LIMIT     = 1'b0,
      CSR_WINDOW_MS = 1'b1
   } csr_index_type;

   // input action codes
   localparam logic ACTION_TICK    = 1'b0;
   localparam logic ACTION_REQUEST = 1'b1;

   // result kind codes
   localparam logic KIND_RELEASE = 1'b0;
   localparam logic KIND_REJECT  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EV_ADDR,
      ST_EV_CHK,
      ST_ENQ,
      ST_REL_ADDR,
      ST_REL_CHK,
      ST_FLUSH
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;   // latch the input beat, advance the clock on a tick
      logic evict;    // drop the oldest log entry
      logic enqueue;  // write the request into the wait queue
      logic reject;   // stage a reject result
      logic issue;    // release the queue head
      logic flush;    // push the staged result as the final one
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic item_req;     // latched beat is a request
      logic log_expired;  // log not empty and its oldest entry is out of window
      logic wait_full;    // wait queue full
      logic release_ok;   // queue not empty, limit allows, result cap not reached
      logic pend_valid;   // a result is staged
      logic out_free;     // output register can take a result this cycle
   } dp_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/sliding_window_release_limiter_core.sv
// Sliding-window release limiter.
// req channel: one beat is either a millisecond tick (tuser = 0) or a new
// request whose id rides in tdata (tuser = 1). Requests queue in a FIFO and
// are released oldest first, at most limit releases in any window of
// window_ms ticks (limit negative = unlimited, 0 = none released).
// rsp channel: one beat per released request (tuser = 0) or per request
// turned away because the queue was full (tuser = 1); tlast marks the final
// result caused by one input beat. A beat causes at most 16 results and may
// cause none.
// csr port: csr_we with csr_addr 0 writes the release limit, 1 writes window_ms.
// Timing: one input beat at a time. After acceptance the controller evicts
// expired log entries, then enqueues or rejects a request, then releases
// queue entries, then flushes the staged result; both loops walk a single
// read port of their RAM. A reject is staged before any release of its beat.
// Reset clears the clock, the log and the queue and both registers; RAM
// contents are not cleared and need no clearing pass.
// A stalled receiver holds the last result in the output register; the
// release loop then waits with the next one staged, no result is lost.
`default_nettype none

module sliding_window_release_limiter_core #(
   parameter int LOG_DEPTH  = swrl_pkg::LOG_DEPTH_DEF,
   parameter int WAIT_DEPTH = swrl_pkg::WAIT_DEPTH_DEF,
   parameter int ID_BITS    = swrl_pkg::ID_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input beats
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [swrl_pkg::ID_W-1:0]       req_tdata,  // [15:0] request_id
   input  wire logic                            req_tuser,  // [0] action
   // results
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [swrl_pkg::ID_W-1:0]       rsp_tdata,  // [15:0] released_id
   output logic                                 rsp_tuser,  // [0] kind
   output logic                                 rsp_tlast,
   // configuration writes
   input  wire logic                            csr_we,
   input  wire logic [swrl_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [swrl_pkg::CSR_DATA_W-1:0] csr_wdata
);

   swrl_pkg::dp_cmd_type    cmd;
   swrl_pkg::dp_status_type sts;

   swrl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   swrl_datapath #(
      .LOG_DEPTH  (LOG_DEPTH),
      .WAIT_DEPTH (WAIT_DEPTH),
      .ID_BITS    (ID_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // no result may stay staged once the block is ready for a new beat
   a_no_pend_when_ready : assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !sts.pend_valid)
      else $error("staged result left behind at item boundary");

   // a release never overwrites a staged result the output cannot take
   a_issue_has_room : assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (sts.release_ok && (!sts.pend_valid || sts.out_free)))
      else $error("release issued without room or permission");

   // rejects happen only on a full queue and only for requests
   a_reject_full : assert property (@(posedge clock) disable iff (reset)
      cmd.reject |-> (sts.wait_full && sts.item_req && !sts.pend_valid))
      else $error("reject without full queue");

   // the final result of an item leaves with tlast on the next cycle
   a_flush_last : assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> (rsp_tvalid && rsp_tlast))
      else $error("final result not marked last");

endmodule

`default_nettype wire

>>> hw/rtl/swrl_ram.sv
`default_nettype none

module swrl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port (read returns old data)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/swrl_ctrl.sv
`default_nettype none

module swrl_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire swrl_pkg::dp_status_type sts,
   output swrl_pkg::dp_cmd_type         cmd
);

   swrl_pkg::ctrl_state_type state_ff;
   swrl_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swrl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         swrl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = swrl_pkg::ST_EV_ADDR;
            end
         end
         // log head address settles, read data comes next cycle
         swrl_pkg::ST_EV_ADDR: begin
            state_in = swrl_pkg::ST_EV_CHK;
         end
         swrl_pkg::ST_EV_CHK: begin
            if (sts.log_expired) begin
               cmd.evict = 1'b1;
               state_in  = swrl_pkg::ST_EV_ADDR;
            end else begin
               state_in = swrl_pkg::ST_ENQ;
            end
         end
         swrl_pkg::ST_ENQ: begin
            if (sts.item_req) begin
               if (sts.wait_full) begin
                  cmd.reject = 1'b1;
               end else begin
                  cmd.enqueue = 1'b1;
               end
            end
            state_in = swrl_pkg::ST_REL_ADDR;
         end
         // queue head address settles
         swrl_pkg::ST_REL_ADDR: begin
            state_in = swrl_pkg::ST_REL_CHK;
         end
         swrl_pkg::ST_REL_CHK: begin
            if (sts.release_ok) begin
               // a staged result must move out before a new one is staged
               if (!sts.pend_valid || sts.out_free) begin
                  cmd.issue = 1'b1;
                  state_in  = swrl_pkg::ST_REL_ADDR;
               end
            end else begin
               state_in = swrl_pkg::ST_FLUSH;
            end
         end
         swrl_pkg::ST_FLUSH: begin
            if (!sts.pend_valid) begin
               state_in = swrl_pkg::ST_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = swrl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swrl_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/swrl_datapath.sv
`default_nettype none

module swrl_datapath #(
   parameter int LOG_DEPTH  = swrl_pkg::LOG_DEPTH_DEF,
   parameter int WAIT_DEPTH = swrl_pkg::WAIT_DEPTH_DEF,
   parameter int ID_BITS    = swrl_pkg::ID_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [swrl_pkg::ID_W-1:0]         req_tdata,
   input  wire logic                              req_tuser,
   input  wire logic                              csr_we,
   input  wire logic [swrl_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [swrl_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire swrl_pkg::dp_cmd_type              cmd,
   output swrl_pkg::dp_status_type                sts,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [swrl_pkg::ID_W-1:0]         rsp_tdata,
   output logic                                   rsp_tuser,
   output logic                                   rsp_tlast
);

   localparam int LOG_AW  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int LOG_CW  = $clog2(LOG_DEPTH + 1);
   localparam int WAIT_AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int WAIT_CW = $clog2(WAIT_DEPTH + 1);
   localparam int LIM_W   = (LOG_CW > swrl_pkg::RATE_W - 1) ? LOG_CW : swrl_pkg::RATE_W - 1;

   // configuration
   logic [swrl_pkg::RATE_W-1:0]     rate_ff;
   logic [swrl_pkg::WINDOW_W-1:0]   window_ff;

   // clock, log and queue pointers
   logic [swrl_pkg::TIME_W-1:0]     time_ff,       time_in;
   logic [LOG_AW-1:0]               log_head_ff,   log_head_in;
   logic [LOG_CW-1:0]               log_count_ff,  log_count_in;
   logic [WAIT_AW-1:0]              wait_head_ff,  wait_head_in;
   logic [WAIT_CW-1:0]              wait_count_ff, wait_count_in;
   logic [swrl_pkg::RESULT_CNT_W-1:0] n_ff,        n_in;

   // latched input beat
   logic                            item_req_ff;
   logic [ID_BITS-1:0]              item_id_ff;

   // staged result and output register
   logic                            pend_valid_ff, pend_valid_in;
   logic                            pend_kind_ff;
   logic [ID_BITS-1:0]              pend_id_ff;
   logic                            out_valid_ff,  out_valid_in;
   logic                            out_kind_ff;
   logic [swrl_pkg::ID_W-1:0]       out_id_ff;
   logic                            out_last_ff;

   // memory ports
   logic [swrl_pkg::TIME_W-1:0]     log_rd_data;
   logic [LOG_AW-1:0]               log_wr_addr;
   logic [ID_BITS-1:0]              wait_rd_data;
   logic [WAIT_AW-1:0]              wait_tail;

   logic [LOG_AW-1:0]               log_head_next;
   logic [WAIT_AW-1:0]              wait_head_next;
   logic [LOG_CW:0]                 log_sum;
   logic [LOG_CW:0]                 log_tail_wide;
   logic [WAIT_CW:0]                wait_sum;
   logic [WAIT_CW:0]                wait_tail_wide;
   logic                            log_full;
   logic [swrl_pkg::TIME_W-1:0]     age;
   logic [LIM_W-1:0]                limit_raw;
   logic [LIM_W-1:0]                limit_cap;
   logic                            may_release;
   logic                            out_free;
   logic                            push;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= '0;
         window_ff <= '0;
      end else if (csr_we) begin
         unique case (swrl_pkg::csr_index_type'(csr_addr))
            swrl_pkg::CSR_LIMIT:     rate_ff   <= csr_wdata[swrl_pkg::RATE_W-1:0];
            swrl_pkg::CSR_WINDOW_MS: window_ff <= csr_wdata[swrl_pkg::WINDOW_W-1:0];
         endcase
      end
   end

   // ring pointer arithmetic
   assign log_head_next  = (log_head_ff == LOG_AW'(LOG_DEPTH - 1)) ? '0 : log_head_ff + 1'b1;
   assign wait_head_next = (wait_head_ff == WAIT_AW'(WAIT_DEPTH - 1)) ? '0
                         : wait_head_ff + 1'b1;

   assign log_sum        = (LOG_CW + 1)'(log_head_ff) + (LOG_CW + 1)'(log_count_ff);
   assign log_tail_wide  = (log_sum >= (LOG_CW + 1)'(LOG_DEPTH))
                         ? log_sum - (LOG_CW + 1)'(LOG_DEPTH) : log_sum;
   assign wait_sum       = (WAIT_CW + 1)'(wait_head_ff) + (WAIT_CW + 1)'(wait_count_ff);
   assign wait_tail_wide = (wait_sum >= (WAIT_CW + 1)'(WAIT_DEPTH))
                         ? wait_sum - (WAIT_CW + 1)'(WAIT_DEPTH) : wait_sum;
   assign wait_tail      = wait_tail_wide[WAIT_AW-1:0];

   // a full log overwrites its oldest entry
   assign log_full    = (log_count_ff == LOG_CW'(LOG_DEPTH));
   assign log_wr_addr = log_full ? log_head_ff : log_tail_wide[LOG_AW-1:0];

   // age of the oldest release, modulo 2^32
   assign age = time_ff - log_rd_data;

   // limit check: negative is unlimited, above log depth acts as log depth
   assign limit_raw   = LIM_W'(rate_ff[swrl_pkg::RATE_W-2:0]);
   assign limit_cap   = (limit_raw > LIM_W'(LOG_DEPTH)) ? LIM_W'(LOG_DEPTH) : limit_raw;
   assign may_release = rate_ff[swrl_pkg::RATE_W-1] || (LIM_W'(log_count_ff) < limit_cap);

   assign out_free = !out_valid_ff || rsp_tready;
   assign push     = (cmd.issue && pend_valid_ff) || cmd.flush;

   // status
   always_comb begin
      sts.item_req    = item_req_ff;
      sts.log_expired = (log_count_ff != '0) && (age >= swrl_pkg::TIME_W'(window_ff));
      sts.wait_full   = (wait_count_ff == WAIT_CW'(WAIT_DEPTH));
      sts.release_ok  = (wait_count_ff != '0) && may_release
                      && (n_ff < swrl_pkg::RESULT_CNT_W'(swrl_pkg::RESULT_CAP));
      sts.pend_valid  = pend_valid_ff;
      sts.out_free    = out_free;
   end

   // next values of the control state
   always_comb begin
      time_in       = time_ff;
      log_head_in   = log_head_ff;
      log_count_in  = log_count_ff;
      wait_head_in  = wait_head_ff;
      wait_count_in = wait_count_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      out_valid_in  = out_valid_ff;

      if (cmd.accept) begin
         n_in = '0;
         if (req_tuser == swrl_pkg::ACTION_TICK) begin
            time_in = time_ff + 1'b1;
         end
      end
      if (cmd.evict) begin
         log_head_in  = log_head_next;
         log_count_in = log_count_ff - 1'b1;
      end
      if (cmd.enqueue) begin
         wait_count_in = wait_count_ff + 1'b1;
      end
      if (cmd.reject) begin
         pend_valid_in = 1'b1;
         n_in          = n_ff + 1'b1;
      end
      if (cmd.issue) begin
         pend_valid_in = 1'b1;
         n_in          = n_ff + 1'b1;
         wait_head_in  = wait_head_next;
         wait_count_in = wait_count_ff - 1'b1;
         if (log_full) begin
            log_head_in = log_head_next;
         end else begin
            log_count_in = log_count_ff + 1'b1;
         end
      end
      if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end

      // output register
      if (push) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff       <= '0;
         log_head_ff   <= '0;
         log_count_ff  <= '0;
         wait_head_ff  <= '0;
         wait_count_ff <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         item_req_ff   <= 1'b0;
      end else begin
         time_ff       <= time_in;
         log_head_ff   <= log_head_in;
         log_count_ff  <= log_count_in;
         wait_head_ff  <= wait_head_in;
         wait_count_ff <= wait_count_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         if (cmd.accept) begin
            item_req_ff <= (req_tuser == swrl_pkg::ACTION_REQUEST);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_id_ff <= ID_BITS'(req_tdata);
      end
      if (cmd.reject) begin
         pend_kind_ff <= swrl_pkg::KIND_REJECT;
         pend_id_ff   <= item_id_ff;
      end else if (cmd.issue) begin
         pend_kind_ff <= swrl_pkg::KIND_RELEASE;
         pend_id_ff   <= wait_rd_data;
      end
      if (push) begin
         out_kind_ff <= pend_kind_ff;
         out_id_ff   <= swrl_pkg::ID_W'(pend_id_ff);
         out_last_ff <= cmd.flush;
      end
   end

   // release time log
   swrl_ram #(
      .WIDTH (swrl_pkg::TIME_W),
      .DEPTH (LOG_DEPTH)
   ) u_log_ram (
      .clock   (clock),
      .wr_en   (cmd.issue),
      .wr_addr (log_wr_addr),
      .wr_data (time_ff),
      .rd_addr (log_head_ff),
      .rd_data (log_rd_data)
   );

   // waiting request ids
   swrl_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (WAIT_DEPTH)
   ) u_wait_ram (
      .clock   (clock),
      .wr_en   (cmd.enqueue),
      .wr_addr (wait_tail),
      .wr_data (item_id_ff),
      .rd_addr (wait_head_ff),
      .rd_data (wait_rd_data)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_id_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire
